// ----- hw/rtl/pid_controller_step_unit_macros.svh -----
// Assertion macros shared by the PID step unit RTL
`ifndef PID_CONTROLLER_STEP_UNIT_MACROS_SVH
`define PID_CONTROLLER_STEP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define PCS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcs: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define PCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcs: next-cycle check failed");

`endif

// ----- hw/rtl/pcs_pkg.sv -----
// Shared types, codes and constants of the PID step unit
`default_nettype none

package pcs_pkg;

	localparam int REG_W      = 32;   // width of every gain register
	localparam int CFG_IDX_W  = 2;
	localparam int NUM_W      = 64;   // dividend width of the integral divide
	localparam int MUL_STEPS  = REG_W;
	localparam int DIV_STEPS  = NUM_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [NUM_W-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_DIV    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;

	typedef struct packed {
		logic signed [REG_W-1:0] prop_gain;
		logic signed [REG_W-1:0] int_div;
		logic signed [REG_W-1:0] deriv_gain;
	} cfg_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [13:0] {
		S_IDLE  = 14'h0001,
		S_ERR   = 14'h0002,
		S_SUM   = 14'h0004,
		S_DIFF  = 14'h0008,
		S_PLOAD = 14'h0010,
		S_PMUL  = 14'h0020,
		S_PACC  = 14'h0040,
		S_DLOAD = 14'h0080,
		S_DMUL  = 14'h0100,
		S_DACC  = 14'h0200,
		S_ILOAD = 14'h0400,
		S_IDIV  = 14'h0800,
		S_IACC  = 14'h1000,
		S_DONE  = 14'h2000
	} state_t;

	// term magnitudes are capped at 2^61
	function automatic logic [NUM_W-1:0] term_clamp(input logic [NUM_W-1:0] x);
		return (x > TERM_LIMIT) ? TERM_LIMIT : x;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcs_alu.sv -----
// Shared add/subtract unit of the PID step unit
`default_nettype none

module pcs_alu #(
	parameter int W = 66
) (
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	input  pcs_pkg::alu_op_t op,
	output logic [W-1:0]     y
);

	logic          sub;
	logic [W-1:0]  b_eff;

	assign sub   = (op == pcs_pkg::ALU_SUB);
	assign b_eff = sub ? ~b : b;
	assign y     = a + b_eff + W'(sub);

endmodule

`default_nettype wire

// ----- hw/rtl/pcs_sat.sv -----
// Signed saturation from a wide value to a narrower signed range
`default_nettype none

module pcs_sat #(
	parameter int IN_W  = 66,
	parameter int OUT_W = 32
) (
	input  logic [IN_W-1:0]  x,
	output logic [OUT_W-1:0] y
);

	logic fits;

	// in range when every bit above the output sign matches it
	assign fits = (x[IN_W-1:OUT_W-1] == {(IN_W-OUT_W+1){x[IN_W-1]}});

	always_comb begin
		if (fits) begin
			y = x[OUT_W-1:0];
		end else if (x[IN_W-1]) begin
			y = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pcs_cfg.sv -----
// Gain and divisor registers of the PID step unit
`default_nettype none

module pcs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcs_pkg::REG_W-1:0]          cfg_data,
	output pcs_pkg::cfg_t                      cfg
);

	pcs_pkg::cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				pcs_pkg::CFG_PROP_GAIN:  regs_q.prop_gain  <= cfg_data;
				pcs_pkg::CFG_INT_DIV:    regs_q.int_div    <= cfg_data;
				pcs_pkg::CFG_DERIV_GAIN: regs_q.deriv_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pid_controller_step_unit.sv -----
// PID step unit: one shared adder run by a one-hot sequencer, Q16.16 by default.
// Each transaction runs the error, sum and difference steps, then the 32-step shift-add
//   multiplies for P and D and the 64-step restoring divide for I on the shared adder;
//   a zero divisor skips the divide. A new transaction is accepted only in idle, once
//   the previous result has moved into the output register.
// Reset: arst_n clears the gains, the error sum, the last error and the sequencer.
`default_nettype none

`include "pid_controller_step_unit_macros.svh"

module pid_controller_step_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int SUM_WIDTH  = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcs_pkg::REG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DATA_WIDTH-1:0]        target_value,
	input  logic signed [DATA_WIDTH-1:0]        measured_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [DATA_WIDTH-1:0]        drive_value
);

	localparam int DW    = DATA_WIDTH;
	localparam int SW    = SUM_WIDTH;
	localparam int RW    = pcs_pkg::REG_W;
	localparam int NW    = pcs_pkg::NUM_W;
	localparam int AW    = (SW + 2 > 66) ? SW + 2 : 66;
	localparam int PW    = RW + DW;
	localparam int OW    = (DW > RW) ? DW : RW;
	localparam int CW    = pcs_pkg::CNT_W;

	pcs_pkg::cfg_t   cfg;
	pcs_pkg::state_t state_q;

	logic [CW-1:0]           cnt_q;
	logic signed [DW-1:0]    tgt_q;
	logic signed [DW-1:0]    meas_q;
	logic signed [DW-1:0]    err_q;
	logic signed [SW-1:0]    err_sum_q;
	logic signed [DW-1:0]    last_err_q;
	logic signed [DW:0]      diff_q;
	logic [OW-1:0]           opnd_q;
	logic                    neg_q;
	logic [PW-1:0]           mreg_q;
	logic [RW+NW-1:0]        dreg_q;
	logic signed [AW-1:0]    drive_q;
	logic                    out_valid_q;
	logic [DW-1:0]           out_drive_q;

	logic [AW-1:0]           alu_a;
	logic [AW-1:0]           alu_b;
	logic [AW-1:0]           alu_y;
	pcs_pkg::alu_op_t        alu_op;

	logic [DW-1:0]           err_next;
	logic [SW-1:0]           sum_next;
	logic [DW-1:0]           drive_sat;

	logic [DW-1:0]           err_mag;
	logic [DW:0]             diff_mag;
	logic [SW-1:0]           sum_mag;
	logic [RW-1:0]           kp_mag;
	logic [RW-1:0]           kd_mag;
	logic [RW-1:0]           ki_mag;
	logic [NW-1:0]           sum_wide;
	logic [NW-1:0]           div_num;
	logic                    prod_ovf;
	logic [NW-1:0]           prod_sat;
	logic [NW-1:0]           mul_term;
	logic [NW-1:0]           div_term;
	logic [RW-1:0]           rem;
	logic [NW-1:0]           quo;
	logic [RW-1:0]           partial;
	logic                    ge;
	logic                    out_free;

	pcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcs_alu #(.W(AW)) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.y  (alu_y)
	);

	pcs_sat #(.IN_W(AW), .OUT_W(DW)) u_err_sat (.x(alu_y), .y(err_next));
	pcs_sat #(.IN_W(AW), .OUT_W(SW)) u_sum_sat (.x(alu_y), .y(sum_next));
	pcs_sat #(.IN_W(AW), .OUT_W(DW)) u_drv_sat (.x(drive_q), .y(drive_sat));

	// operand magnitudes, taken when a multiply or divide is loaded
	always_comb begin
		err_mag  = err_q[DW-1] ? -err_q : err_q;
		diff_mag = diff_q[DW] ? -diff_q : diff_q;
		sum_mag  = err_sum_q[SW-1] ? -err_sum_q : err_sum_q;
		kp_mag   = cfg.prop_gain[RW-1] ? -cfg.prop_gain : cfg.prop_gain;
		kd_mag   = cfg.deriv_gain[RW-1] ? -cfg.deriv_gain : cfg.deriv_gain;
		ki_mag   = cfg.int_div[RW-1] ? -cfg.int_div : cfg.int_div;
	end

	// dividend is |sum| << FRAC_BITS, pinned to all ones when it would not fit
	assign sum_wide = NW'(sum_mag);
	assign div_num  = (sum_wide > ({NW{1'b1}} >> FRAC_BITS)) ? {NW{1'b1}}
		: (sum_wide << FRAC_BITS);

	// product saturates at 64 bits before the fraction shift
	assign prod_ovf = |(mreg_q >> NW);
	assign prod_sat = prod_ovf ? {NW{1'b1}} : NW'(mreg_q);
	assign mul_term = pcs_pkg::term_clamp(prod_sat >> FRAC_BITS);

	assign rem      = dreg_q[RW+NW-1:NW];
	assign quo      = dreg_q[NW-1:0];
	assign div_term = pcs_pkg::term_clamp(quo);
	assign partial  = {rem[RW-2:0], quo[NW-1]};
	assign ge       = !alu_y[AW-1];

	always_comb begin
		alu_a  = '0;
		alu_b  = '0;
		alu_op = pcs_pkg::ALU_ADD;
		case (state_q)
			pcs_pkg::S_ERR: begin
				alu_a  = AW'(tgt_q);
				alu_b  = AW'(meas_q);
				alu_op = pcs_pkg::ALU_SUB;
			end
			pcs_pkg::S_SUM: begin
				alu_a = AW'(err_sum_q);
				alu_b = AW'(err_q);
			end
			pcs_pkg::S_DIFF: begin
				alu_a  = AW'(err_q);
				alu_b  = AW'(last_err_q);
				alu_op = pcs_pkg::ALU_SUB;
			end
			pcs_pkg::S_PMUL, pcs_pkg::S_DMUL: begin
				alu_a = AW'(mreg_q[PW-1:RW]);
				alu_b = mreg_q[0] ? AW'(opnd_q[DW-1:0]) : '0;
			end
			pcs_pkg::S_IDIV: begin
				alu_a  = AW'(partial);
				alu_b  = AW'(opnd_q[RW-1:0]);
				alu_op = pcs_pkg::ALU_SUB;
			end
			pcs_pkg::S_PACC, pcs_pkg::S_DACC: begin
				alu_a  = drive_q;
				alu_b  = AW'(mul_term);
				alu_op = neg_q ? pcs_pkg::ALU_SUB : pcs_pkg::ALU_ADD;
			end
			pcs_pkg::S_IACC: begin
				alu_a  = drive_q;
				alu_b  = AW'(div_term);
				alu_op = neg_q ? pcs_pkg::ALU_SUB : pcs_pkg::ALU_ADD;
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcs_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			err_sum_q   <= '0;
			last_err_q  <= '0;
		end else begin
			// a finished result refills the output register, else a taken one empties it
			if (state_q == pcs_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pcs_pkg::S_IDLE: begin
					if (in_valid) begin
						state_q <= pcs_pkg::S_ERR;
					end
				end
				pcs_pkg::S_ERR:  state_q <= pcs_pkg::S_SUM;
				pcs_pkg::S_SUM: begin
					err_sum_q <= sum_next;
					state_q   <= pcs_pkg::S_DIFF;
				end
				pcs_pkg::S_DIFF: begin
					last_err_q <= err_q;
					state_q    <= pcs_pkg::S_PLOAD;
				end
				pcs_pkg::S_PLOAD: begin
					cnt_q   <= CW'(pcs_pkg::MUL_STEPS - 1);
					state_q <= pcs_pkg::S_PMUL;
				end
				pcs_pkg::S_PMUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= pcs_pkg::S_PACC;
					end
				end
				pcs_pkg::S_PACC: state_q <= pcs_pkg::S_DLOAD;
				pcs_pkg::S_DLOAD: begin
					cnt_q   <= CW'(pcs_pkg::MUL_STEPS - 1);
					state_q <= pcs_pkg::S_DMUL;
				end
				pcs_pkg::S_DMUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= pcs_pkg::S_DACC;
					end
				end
				pcs_pkg::S_DACC: state_q <= pcs_pkg::S_ILOAD;
				pcs_pkg::S_ILOAD: begin
					// zero divisor drops the integral term
					if (cfg.int_div == '0) begin
						state_q <= pcs_pkg::S_DONE;
					end else begin
						cnt_q   <= CW'(pcs_pkg::DIV_STEPS - 1);
						state_q <= pcs_pkg::S_IDIV;
					end
				end
				pcs_pkg::S_IDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= pcs_pkg::S_IACC;
					end
				end
				pcs_pkg::S_IACC: state_q <= pcs_pkg::S_DONE;
				pcs_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= pcs_pkg::S_IDLE;
					end
				end
				default: state_q <= pcs_pkg::S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pcs_pkg::S_IDLE: begin
				tgt_q  <= target_value;
				meas_q <= measured_value;
			end
			pcs_pkg::S_ERR: begin
				err_q   <= err_next;
				drive_q <= '0;
			end
			pcs_pkg::S_DIFF: diff_q <= alu_y[DW:0];
			pcs_pkg::S_PLOAD: begin
				opnd_q <= OW'(err_mag);
				mreg_q <= {{DW{1'b0}}, kp_mag};
				neg_q  <= cfg.prop_gain[RW-1] ^ err_q[DW-1];
			end
			pcs_pkg::S_DLOAD: begin
				opnd_q <= OW'(diff_mag[DW-1:0]);
				mreg_q <= {{DW{1'b0}}, kd_mag};
				neg_q  <= cfg.deriv_gain[RW-1] ^ diff_q[DW];
			end
			pcs_pkg::S_PMUL, pcs_pkg::S_DMUL: begin
				mreg_q <= {alu_y[DW:0], mreg_q[RW-1:1]};
			end
			pcs_pkg::S_PACC, pcs_pkg::S_DACC, pcs_pkg::S_IACC: begin
				drive_q <= alu_y;
			end
			pcs_pkg::S_ILOAD: begin
				opnd_q <= OW'(ki_mag);
				dreg_q <= {{RW{1'b0}}, div_num};
				neg_q  <= err_sum_q[SW-1] ^ cfg.int_div[RW-1];
			end
			pcs_pkg::S_IDIV: begin
				dreg_q <= {(ge ? alu_y[RW-1:0] : partial), quo[NW-2:0], ge};
			end
			pcs_pkg::S_DONE: begin
				if (out_free) begin
					out_drive_q <= drive_sat;
				end
			end
			default: ;
		endcase
	end

	assign in_ready    = (state_q == pcs_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign drive_value = out_drive_q;

	`PCS_ASSERT_NEXT(a_start_on_accept, in_valid && in_ready, state_q == pcs_pkg::S_ERR)
	`PCS_ASSERT_SAME(a_rem_below_dvsr, state_q == pcs_pkg::S_IDIV, rem < opnd_q[RW-1:0])
	`PCS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(drive_value))
	`PCS_ASSERT_SAME(a_last_err_stored, state_q == pcs_pkg::S_DONE, last_err_q == err_q)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for the PID step unit: directed and random transactions checked by a scoreboard
`timescale 1ns / 100ps

module tb_top;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int SUM_W = 48;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_AFTER = 200;
	localparam int HOLD_CYCLES = 800;
	localparam logic [63:0] TERM_CAP = 64'h2000_0000_0000_0000;
	localparam logic [pcs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int Q_ONE = 32'sh0001_0000;
	localparam int DATA_MAX = 32'sh7FFF_FFFF;
	localparam int DATA_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcs_pkg::REG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [DATA_W-1:0] target_value;
	logic signed [DATA_W-1:0] measured_value;
	logic out_valid;
	logic out_ready;
	logic signed [DATA_W-1:0] drive_value;

	pid_controller_step_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_value(target_value),
		.measured_value(measured_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_value(drive_value)
	);

	class drive_scoreboard;
		longint kp;
		longint kdiv;
		longint kd;
		longint err_sum;
		longint prev_err;
		logic signed [DATA_W-1:0] expected_drives[$];
		int fail_count;

		function new();
			kp = 0;
			kdiv = 0;
			kd = 0;
			err_sum = 0;
			prev_err = 0;
			fail_count = 0;
		endfunction

		function void write_reg(logic [pcs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				pcs_pkg::CFG_PROP_GAIN: kp = longint'(signed'(val));
				pcs_pkg::CFG_INT_DIV: kdiv = longint'(signed'(val));
				pcs_pkg::CFG_DERIV_GAIN: kd = longint'(signed'(val));
				default: ;
			endcase
		endfunction

		function longint saturate(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function logic [63:0] abs64(longint v);
			return (v < 0) ? 64'(-v) : 64'(v);
		endfunction

		function longint limit_term(bit neg, logic [63:0] mag);
			logic [63:0] m;
			m = (mag > TERM_CAP) ? TERM_CAP : mag;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		// Q product, truncated toward zero; magnitude overflow saturates before the shift
		function longint scaled_product(longint a, longint b);
			logic [127:0] p;
			p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
			if (p[127:64] != 0)
				p[63:0] = '1;
			return limit_term((a < 0) != (b < 0), p[63:0] >> FRAC_W);
		endfunction

		function longint scaled_quotient(longint s, longint d);
			logic [63:0] ms;
			logic [63:0] md;
			logic [63:0] num;
			if (d == 0)
				return 0;
			ms = abs64(s);
			md = abs64(d);
			num = (ms > (64'hFFFF_FFFF_FFFF_FFFF >> FRAC_W)) ? '1 : (ms << FRAC_W);
			return limit_term((s < 0) != (d < 0), num / md);
		endfunction

		function void note_transaction(int tgt, int meas);
			longint err;
			longint drive;
			err = saturate(longint'(tgt) - longint'(meas), DATA_W);
			err_sum = saturate(err_sum + err, SUM_W);
			drive = scaled_product(kp, err) + scaled_quotient(err_sum, kdiv)
				+ scaled_product(kd, err - prev_err);
			drive = saturate(drive, DATA_W);
			prev_err = err;
			expected_drives.push_back(drive[DATA_W-1:0]);
		endfunction

		function void check_drive(logic signed [DATA_W-1:0] actual);
			logic signed [DATA_W-1:0] want;
			if (expected_drives.size() == 0) begin
				$error("drive_value: expected none, actual %0d", actual);
				fail_count++;
				return;
			end
			want = expected_drives.pop_front();
			if (actual !== want) begin
				$error("drive_value: expected %0d, actual %0d", want, actual);
				fail_count++;
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	drive_scoreboard board;
	int cycle_count = 0;
	int drives_seen = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int setpoint = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_drive(drive_value);
			drives_seen++;
		end
	end

	// receiver: random stall patterns, each held for a random span, and one long hold-off
	initial begin : receiver
		int mode;
		int span;
		int stall;
		int tick;
		bit held;
		bit r;
		mode = 0;
		span = 0;
		stall = 0;
		tick = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && drives_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(50, 300);
			end
			span--;
			tick++;
			case (mode)
				0: r = 1'b1;
				1: r = $urandom_range(0, 1);
				2: r = (tick % 7) < 4;
				default: begin
					if (stall > 0) begin
						r = 1'b0;
						stall--;
					end else begin
						r = 1'b1;
						if ($urandom_range(0, 15) == 0)
							stall = $urandom_range(5, 40);
					end
				end
			endcase
			out_ready <= r;
		end
	end

	task automatic write_reg(input logic [pcs_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		board.write_reg(idx, val);
	endtask

	task automatic set_gains(input int kp, input int kdiv, input int kd, input bit spare);
		write_reg(pcs_pkg::CFG_PROP_GAIN, kp);
		write_reg(pcs_pkg::CFG_INT_DIV, kdiv);
		write_reg(pcs_pkg::CFG_DERIV_GAIN, kd);
		// unused index must leave the gains alone
		if (spare)
			write_reg(CFG_SPARE, $urandom);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_item(input int tgt, input int meas);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 30);
			burst_left = $urandom_range(1, 8);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		target_value <= tgt;
		measured_value <= meas;
		do @(posedge clk); while (!in_ready);
		board.note_transaction(tgt, meas);
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
			0: return DATA_MAX;
			1: return DATA_MIN;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic int pick_small();
		return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return DATA_MAX;
			2: return DATA_MIN;
			3: return Q_ONE;
			4: return -Q_ONE;
			5: return int'($urandom);
			default: return int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
		endcase
	endfunction

	initial begin : stimulus
		int ph;
		int k;
		int t;
		int m;
		board = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		target_value = '0;
		measured_value = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset gains: drive stays zero while the sum accumulates
		gaps_on = 1'b0;
		send_item(32'sh0005_0000, 32'sh0002_0000);
		send_item(DATA_MAX, DATA_MIN);
		drain(4);

		set_gains(Q_ONE, Q_ONE, Q_ONE, 1'b1);
		send_item(0, 0);
		send_item(DATA_MAX, DATA_MIN);
		send_item(DATA_MIN, DATA_MAX);
		send_item(DATA_MAX, DATA_MAX);
		send_item(DATA_MIN, DATA_MIN);
		send_item(Q_ONE, 0);
		send_item(0, Q_ONE);
		send_item(-1, 0);
		send_item(1, -1);
		send_item(DATA_MAX, DATA_MIN);
		send_item(DATA_MIN, DATA_MAX);
		drain(4);

		// divisor zero: integral term off, sum keeps running
		set_gains(Q_ONE, 0, Q_ONE, 1'b0);
		send_item(32'sh0003_8000, 32'sh0001_4000);
		send_item(DATA_MAX, DATA_MIN);
		send_item(-32'sh0002_0000, 32'sh0004_0000);
		drain(4);

		// tiny divisor pushes the integral term hard
		set_gains(DATA_MIN, 1, DATA_MAX, 1'b0);
		send_item(DATA_MAX, DATA_MIN);
		send_item(DATA_MIN, DATA_MAX);
		send_item(32'sh0003_8000, 32'sh0001_4000);
		drain(4);

		set_gains(DATA_MAX, DATA_MIN, DATA_MIN, 1'b1);
		send_item(DATA_MIN, DATA_MAX);
		send_item(DATA_MAX, 0);
		send_item(-1, 1);
		drain(4);

		for (ph = 0; ph < 8; ph++) begin
			set_gains(pick_gain(), pick_gain(), pick_gain(), ph % 2 == 0);
			gaps_on = (ph % 3 != 1);
			for (k = 0; k < 135; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						// loop-like: measurement tracks a slowly stepping setpoint
						if ($urandom_range(0, 15) == 0)
							setpoint = pick_small();
						t = setpoint;
						m = setpoint + int'($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
					end
					5, 6: begin
						t = int'($urandom);
						m = int'($urandom);
					end
					7: begin
						t = pick_extreme();
						m = int'($urandom);
					end
					8: begin
						t = int'($urandom);
						m = pick_extreme();
					end
					default: begin
						t = pick_extreme();
						m = pick_extreme();
					end
				endcase
				send_item(t, m);
			end
			drain(4);
		end

		drain(300);
		if (board.fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
